// ----- design/particle_swarm_update_assert.svh -----
// Assertion macros for the particle swarm update block
`ifndef PARTICLE_SWARM_UPDATE_ASSERT_SVH
`define PARTICLE_SWARM_UPDATE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define PSU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define PSU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ----- design/psu_pkg.sv -----
// ----------------------------------------------------------------------------
// psu_pkg
// Types and constants shared by the particle swarm update block.
// ----------------------------------------------------------------------------
`default_nettype none
package psu_pkg;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CMD_W-1:0] CMD_MOVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INERTIA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GPULL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PPULL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_MUL_E,
        S_WB,
        S_CPY_RD,
        S_CPY_WR,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- design/psu_if.sv -----
// ----------------------------------------------------------------------------
// psu_if
// Valid/ready channel interfaces for the particle swarm update block.
// ----------------------------------------------------------------------------
`default_nettype none
interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [4:0] particle;
    logic [3:0] dimension;
    logic [15:0] rand_global;
    logic [15:0] rand_personal;
    logic signed [31:0] fitness;
    modport source (output valid, cmd, particle, dimension, rand_global,
                    rand_personal, fitness, input ready);
    modport sink (input valid, cmd, particle, dimension, rand_global,
                  rand_personal, fitness, output ready);
endinterface

interface psu_out_if;
    logic valid;
    logic ready;
    logic signed [23:0] new_position;
    logic signed [31:0] best_ever_fitness;
    logic signed [31:0] gen_best_fitness;
    logic signed [23:0] best_ever_coord;
    logic signed [23:0] gen_best_coord;
    modport source (output valid, new_position, best_ever_fitness, gen_best_fitness,
                    best_ever_coord, gen_best_coord, input ready);
    modport sink (input valid, new_position, best_ever_fitness, gen_best_fitness,
                  best_ever_coord, gen_best_coord, output ready);
endinterface

interface psu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/psu_mul.sv -----
// ----------------------------------------------------------------------------
// psu_mul
// Shared registered signed multiplier, 26 x 26 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module psu_mul (
    input  wire logic               i_clk,
    input  wire logic signed [25:0] i_a,
    input  wire logic signed [25:0] i_b,
    output logic signed [51:0]      o_p
);
    logic signed [51:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- design/psu_ram.sv -----
// ----------------------------------------------------------------------------
// psu_ram
// Single-port memory, one write and one registered read of the same address per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psu_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- design/particle_swarm_update.sv -----
// ----------------------------------------------------------------------------
// particle_swarm_update
// Fixed-point particle swarm optimizer, global best with inertia weight.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one command word (move, fitness report, best read);
// out_ch returns one result word per command; cfg_ch writes the five coefficient
// and bound registers; the user must write them only while the block is idle;
// the block itself does not enforce this. Each command is handled alone under a
// sequencer; in_ch.ready is low until the result word has been taken by out_ch.
// Move: the sequencer steps through read, multiply A to E and write-back,
// using the one shared 26x26 multiplier five times in a row (inertia, two
// coefficients, two differences); the first generation skips B to E.
// Fitness report: the particle's position row is copied one element at a time,
// a read then a write through the single memory port, into its personal best
// row and the best vectors, each only when its update condition holds.
// Best read and other words go from accept straight to the output register.
// After reset the block clears its element memories and best vectors, one
// entry a cycle over all 2**(particle bits + dimension bits) addresses
// (PARTICLES*DIMENSIONS when both are powers of two), before in_ch.ready rises.
// A stalled receiver holds the result word in the output register, and no
// new command is accepted until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_swarm_update_assert.svh"
module particle_swarm_update #(
    parameter int PARTICLES  = 32,
    parameter int DIMENSIONS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psu_in_if.sink    in_ch,
    psu_out_if.source out_ch,
    psu_cfg_if.sink   cfg_ch
);
    localparam int PW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int EW = PW + DW;
    localparam int ED = 1 << EW;

    psu_pkg::t_state r_state, n_state;

    logic [17:0] r_w, r_gp, r_pp;
    logic signed [23:0] r_lo, r_hi;

    logic [PW-1:0] r_p;
    logic [DW-1:0] r_d;
    logic [15:0] r_rg, r_rp;
    logic signed [31:0] r_fit;

    logic r_first;
    logic signed [31:0] r_gbs, r_gens;
    logic signed [31:0] r_pbs [PARTICLES];
    logic signed [23:0] r_gbv [DIMENSIONS];
    logic signed [23:0] r_genv [DIMENSIONS];
    logic r_upd_pb, r_upd_gb, r_upd_gen;

    logic [EW-1:0] r_clr;
    logic [DW:0] r_ci;

    logic signed [23:0] r_x, r_v, r_pb;
    logic signed [28:0] r_sum;

    logic signed [23:0] r_o_np, r_o_bec, r_o_gbc;
    logic r_o_valid;

    // memories
    logic        pos_we, vel_we, pb_we;
    logic [EW-1:0] addr;
    logic [23:0] pos_wd, vel_wd, pb_wd, pos_rd, vel_rd, pb_rd;

    psu_ram #(.DEPTH(ED), .WIDTH(24)) u_pos (.i_clk(i_clk), .i_we(pos_we), .i_addr(addr),
        .i_wdata(pos_wd), .o_rdata(pos_rd));
    psu_ram #(.DEPTH(ED), .WIDTH(24)) u_vel (.i_clk(i_clk), .i_we(vel_we), .i_addr(addr),
        .i_wdata(vel_wd), .o_rdata(vel_rd));
    psu_ram #(.DEPTH(ED), .WIDTH(24)) u_pb (.i_clk(i_clk), .i_we(pb_we), .i_addr(addr),
        .i_wdata(pb_wd), .o_rdata(pb_rd));

    // shared multiplier
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_p;
    psu_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    logic in_acc, out_acc;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (r_state == psu_pkg::S_IDLE);
    assign cfg_ch.ready = 1'b1;

    logic p_in_ok, d_in_ok;
    assign p_in_ok = {27'd0, in_ch.particle} < 32'(PARTICLES);
    assign d_in_ok = {28'd0, in_ch.dimension} < 32'(DIMENSIONS);

    logic [DW-1:0] d_idx;
    logic [PW-1:0] p_idx;
    assign d_idx = r_d;
    assign p_idx = r_p;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= 18'd58982;
            r_gp <= 18'd39322;
            r_pp <= 18'd39322;
            r_lo <= 24'sd0;
            r_hi <= 24'sd65536;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                psu_pkg::REG_INERTIA: r_w  <= cfg_ch.data[17:0];
                psu_pkg::REG_GPULL:   r_gp <= cfg_ch.data[17:0];
                psu_pkg::REG_PPULL:   r_pp <= cfg_ch.data[17:0];
                psu_pkg::REG_LOWER:   r_lo <= cfg_ch.data[23:0];
                psu_pkg::REG_UPPER:   r_hi <= cfg_ch.data[23:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psu_pkg::S_CLEAR: if (r_clr == '1) n_state = psu_pkg::S_IDLE;
            psu_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = psu_pkg::S_OUT;
                    if (in_ch.cmd == psu_pkg::CMD_MOVE && p_in_ok && d_in_ok)
                        n_state = psu_pkg::S_RD;
                    else if (in_ch.cmd == psu_pkg::CMD_FIT && p_in_ok)
                        n_state = psu_pkg::S_CPY_RD;
                end
            end
            psu_pkg::S_RD:    n_state = psu_pkg::S_MUL_A;
            psu_pkg::S_MUL_A: n_state = r_first ? psu_pkg::S_WB : psu_pkg::S_MUL_B;
            psu_pkg::S_MUL_B: n_state = psu_pkg::S_MUL_C;
            psu_pkg::S_MUL_C: n_state = psu_pkg::S_MUL_D;
            psu_pkg::S_MUL_D: n_state = psu_pkg::S_MUL_E;
            psu_pkg::S_MUL_E: n_state = psu_pkg::S_WB;
            psu_pkg::S_WB:    n_state = psu_pkg::S_OUT;
            psu_pkg::S_CPY_RD: n_state = (r_ci == (DW+1)'(DIMENSIONS)) ? psu_pkg::S_OUT
                                                                        : psu_pkg::S_CPY_WR;
            psu_pkg::S_CPY_WR: n_state = psu_pkg::S_CPY_RD;
            psu_pkg::S_OUT:   if (out_acc) n_state = psu_pkg::S_IDLE;
            default: n_state = psu_pkg::S_IDLE;
        endcase
    end

    // multiplier operands (product ready in the next cycle)
    logic signed [24:0] gdiff, pdiff;
    assign gdiff = 25'(r_gbv[d_idx]) - 25'(r_x);
    assign pdiff = 25'(r_pb) - 25'(r_x);
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            psu_pkg::S_MUL_A: begin
                if (r_first) begin
                    mul_a = 26'(25'(r_hi) - 25'(r_lo));
                    mul_b = 26'({1'b0, r_rg});
                end else begin
                    mul_a = 26'({1'b0, r_w});
                    mul_b = 26'(r_v);
                end
            end
            psu_pkg::S_MUL_B: begin
                mul_a = 26'({1'b0, r_gp});
                mul_b = 26'({1'b0, r_rg});
            end
            psu_pkg::S_MUL_C: begin
                mul_a = 26'(mul_p >>> 16);
                mul_b = 26'(gdiff);
            end
            psu_pkg::S_MUL_D: begin
                mul_a = 26'({1'b0, r_pp});
                mul_b = 26'({1'b0, r_rp});
            end
            psu_pkg::S_MUL_E: begin
                mul_a = 26'(mul_p >>> 16);
                mul_b = 26'(pdiff);
            end
            default: ;
        endcase
    end

    // memory control
    logic signed [24:0] vsat_src;
    logic signed [23:0] vsat;
    logic signed [24:0] xnew;
    logic signed [23:0] xcl;
    logic signed [28:0] vfull;
    always_comb begin
        vfull = r_sum + 29'(mul_p >>> 16);
        if (vfull > 29'sd8388607) vsat = 24'sd8388607;
        else if (vfull < -29'sd8388608) vsat = -24'sd8388608;
        else vsat = vfull[23:0];
        vsat_src = 25'(r_lo) + 25'(mul_p >>> 16);
        xnew = 25'(r_x) + 25'(vsat);
        if (xnew < 25'(r_lo)) xcl = r_lo;
        else if (xnew > 25'(r_hi)) xcl = r_hi;
        else xcl = xnew[23:0];
    end

    always_comb begin
        pos_we = 1'b0;
        vel_we = 1'b0;
        pb_we  = 1'b0;
        pos_wd = vsat_src[23:0];
        vel_wd = vsat;
        pb_wd  = pos_rd;
        addr   = {p_idx, d_idx};
        unique case (r_state)
            psu_pkg::S_CLEAR: begin
                addr = r_clr;
                pos_we = 1'b1;
                vel_we = 1'b1;
                pb_we  = 1'b1;
                pos_wd = '0;
                vel_wd = '0;
                pb_wd  = '0;
            end
            psu_pkg::S_IDLE: addr = {PW'(in_ch.particle), DW'(in_ch.dimension)};
            psu_pkg::S_WB: begin
                pos_we = 1'b1;
                vel_we = !r_first;
                if (!r_first) pos_wd = xcl;
            end
            psu_pkg::S_CPY_RD: addr = {p_idx, r_ci[DW-1:0]};
            psu_pkg::S_CPY_WR: begin
                addr  = {p_idx, r_ci[DW-1:0]};
                pb_we = r_upd_pb;
            end
            default: ;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= psu_pkg::S_CLEAR;
            r_clr     <= '0;
            r_first   <= 1'b1;
            r_gbs     <= '0;
            r_gens    <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < PARTICLES; i++) r_pbs[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == psu_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (out_acc) r_o_valid <= 1'b0;
            if (r_state != psu_pkg::S_OUT && n_state == psu_pkg::S_OUT) begin
                r_o_valid <= 1'b1;
            end
            if (r_state == psu_pkg::S_CPY_RD && r_ci == (DW+1)'(DIMENSIONS)) begin
                if (r_upd_pb) r_pbs[p_idx] <= r_fit;
                if (r_upd_gb) r_gbs <= r_fit;
                if (r_upd_gen) r_gens <= r_fit;
                if (r_first && r_p == PW'(PARTICLES - 1)) r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psu_pkg::S_CLEAR) begin
            r_gbv[r_clr[DW-1:0]]  <= '0;
            r_genv[r_clr[DW-1:0]] <= '0;
        end
        if (in_acc) begin
            r_p   <= PW'(in_ch.particle);
            r_d   <= DW'(in_ch.dimension);
            r_rg  <= in_ch.rand_global;
            r_rp  <= in_ch.rand_personal;
            r_fit <= in_ch.fitness;
            r_ci  <= '0;
            r_o_np  <= '0;
            if (in_ch.cmd == psu_pkg::CMD_READ && d_in_ok) begin
                r_o_bec <= r_gbv[DW'(in_ch.dimension)];
                r_o_gbc <= r_genv[DW'(in_ch.dimension)];
            end else begin
                r_o_bec <= '0;
                r_o_gbc <= '0;
            end
            if (in_ch.cmd == psu_pkg::CMD_FIT) begin
                r_upd_pb  <= r_first || (in_ch.fitness > r_pbs[PW'(in_ch.particle)]);
                r_upd_gb  <= (r_first && in_ch.particle == '0) || (in_ch.fitness > r_gbs);
                r_upd_gen <= (in_ch.particle == '0) || (in_ch.fitness > r_gens);
            end else begin
                r_upd_pb  <= 1'b0;
                r_upd_gb  <= 1'b0;
                r_upd_gen <= 1'b0;
            end
        end
        unique case (r_state)
            psu_pkg::S_RD: begin
                r_x  <= pos_rd;
                r_v  <= vel_rd;
                r_pb <= pb_rd;
            end
            psu_pkg::S_MUL_B: r_sum <= 29'(mul_p >>> 16);
            psu_pkg::S_MUL_D: r_sum <= r_sum + 29'(mul_p >>> 16);
            psu_pkg::S_WB: r_o_np <= r_first ? vsat_src[23:0] : xcl;
            psu_pkg::S_CPY_RD: ;
            psu_pkg::S_CPY_WR: begin
                if (r_upd_gb)  r_gbv[r_ci[DW-1:0]]  <= pos_rd;
                if (r_upd_gen) r_genv[r_ci[DW-1:0]] <= pos_rd;
                r_ci <= r_ci + 1'b1;
            end
            default: ;
        endcase
    end

    assign out_ch.valid             = r_o_valid;
    assign out_ch.new_position      = r_o_np;
    assign out_ch.best_ever_fitness = r_gbs;
    assign out_ch.gen_best_fitness  = r_gens;
    assign out_ch.best_ever_coord   = r_o_bec;
    assign out_ch.gen_best_coord    = r_o_gbc;

    `PSU_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, out_ch.valid, r_state == psu_pkg::S_OUT)
    `PSU_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != psu_pkg::S_IDLE, !in_ch.ready)
    `PSU_ASSERT_NEXT(a_first_sticky, i_clk, i_rst_n, !r_first, !r_first)
    `PSU_ASSERT_IMP(a_copy_bound, i_clk, i_rst_n, r_state == psu_pkg::S_CPY_WR,
        r_ci < (DW+1)'(DIMENSIONS))
endmodule
`default_nettype wire
